### rtl/core/tcps_pkg.sv
// Shared types and codes for the two-class priority FIFO scheduler.
package tcps_pkg;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [2:0] ST_ADDED  = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_URGENT = 3'd2;
  localparam logic [2:0] ST_NORMAL = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  localparam logic [3:0] THRESHOLD_RESET = 4'd5;

  // Result queue depth and its index and level widths.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_IW    = 2;
  localparam int OUTQ_LW    = 3;

  typedef enum logic [1:0] {
    OP_ADD_URGENT,
    OP_ADD_NORMAL,
    OP_TAKE
  } op_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] entry_id;
    logic [3:0]  severity;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [3:0]  served_severity;
    logic        server_select;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  sev;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] id;
    logic [3:0]  sev;
  } cls_req_t;

endpackage

### rtl/core/two_class_priority_fifo_scheduler.sv
// Top level of the two-class priority FIFO scheduler.
//
//   channel   handshake        payload
//   input     push / full      in_data   (mode, entry_id, severity)
//   result    empty / pop      out_data  (status, served_id, served_severity, server_select)
//   config    cfg_we           cfg_wdata (urgent threshold)
//
// One request per cycle is sustained while the result side keeps popping; a request's
// result reaches the result ports through the request queue, the back-end result stage
// with the registered read of the normal FIFO memory, then the result queue.
// Reset clears all counters and queues at once; no clearing pass is needed.
// When the result side stalls, the result queue fills, then the request queue,
// and full rises.
module two_class_priority_fifo_scheduler
  import tcps_pkg::*;
#(
  parameter int URGENT_DEPTH = 16,
  parameter int NORMAL_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_req_t    in_data,
  output logic       empty,
  input  logic       pop,
  output out_rsp_t   out_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic               req_valid, req_take, rsp_valid;
  cls_req_t           req_data;
  out_rsp_t           rsp_data;
  logic [OUTQ_LW-1:0] outq_level;

  tcps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_data  (req_data),
    .req_take  (req_take)
  );

  tcps_back #(
    .URGENT_DEPTH (URGENT_DEPTH),
    .NORMAL_DEPTH (NORMAL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_data   (req_data),
    .req_take   (req_take),
    .outq_level (outq_level),
    .rsp_valid  (rsp_valid),
    .rsp_data   (rsp_data)
  );

  tcps_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (rsp_valid),
    .wr_data  (rsp_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .level    (outq_level)
  );

endmodule

### rtl/core/tcps_front.sv
// Front end: threshold register, request classification and the request queue.
module tcps_front
  import tcps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_req_t  in_data,
  input  logic     cfg_we,
  input  logic [3:0] cfg_wdata,
  output logic     req_valid,
  output cls_req_t req_data,
  input  logic     req_take
);

  logic [3:0] thr_r;
  cls_req_t   q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  cls_req_t   cls;

  assign full      = (cnt_r == 2'd2);
  assign acc       = push && !full;
  assign req_valid = (cnt_r != 2'd0);
  assign req_data  = q_r[rd_ptr_r];

  always_comb begin
    cls.id  = in_data.entry_id;
    cls.sev = in_data.severity;
    if (in_data.mode == MODE_TAKE) begin
      cls.op = OP_TAKE;
    end else if (in_data.severity > thr_r) begin
      cls.op = OP_ADD_URGENT;
    end else begin
      cls.op = OP_ADD_NORMAL;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !req_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!acc && req_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (acc) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (req_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/core/tcps_back.sv
// Back end: ordered urgent store, normal FIFO memory, parity and result stage.
module tcps_back
  import tcps_pkg::*;
#(
  parameter int URGENT_DEPTH = 16,
  parameter int NORMAL_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  cls_req_t          req_data,
  output logic              req_take,
  input  logic [OUTQ_LW-1:0] outq_level,
  output logic              rsp_valid,
  output out_rsp_t          rsp_data
);

  localparam int UCW = $clog2(URGENT_DEPTH + 1);
  localparam int NCW = $clog2(NORMAL_DEPTH + 1);
  localparam int NIW = $clog2(NORMAL_DEPTH);

  // Urgent store: a row of cells kept in descending severity order.
  entry_t u_r   [URGENT_DEPTH];
  entry_t u_nxt [URGENT_DEPTH];
  logic [URGENT_DEPTH-1:0] ge;
  logic [UCW-1:0] ucount_r;

  entry_t normal_mem [NORMAL_DEPTH];
  entry_t rd_r;
  logic [NIW-1:0] head_r, tail_r;
  logic [NCW-1:0] ncount_r;
  logic           parity_r;

  logic       b_valid_r, b_from_mem_r, b_sel_r;
  logic [2:0] b_status_r;
  entry_t     b_ent_r;

  logic [OUTQ_LW:0] pending;
  logic fire, ins, upop, nwr, nrd, toggle;
  logic [2:0] status;
  entry_t new_ent;

  assign pending  = {1'b0, outq_level} + {{OUTQ_LW{1'b0}}, b_valid_r};
  assign fire     = req_valid && (pending < (OUTQ_LW+1)'(OUTQ_DEPTH));
  assign req_take = fire;
  assign new_ent  = '{id: req_data.id, sev: req_data.sev};

  always_comb begin
    ins    = 1'b0;
    upop   = 1'b0;
    nwr    = 1'b0;
    nrd    = 1'b0;
    status = ST_EMPTY;
    case (req_data.op)
      OP_ADD_URGENT: begin
        if (ucount_r == UCW'(URGENT_DEPTH)) begin
          status = ST_FULL;
        end else begin
          ins    = fire;
          status = ST_ADDED;
        end
      end
      OP_ADD_NORMAL: begin
        if (ncount_r == NCW'(NORMAL_DEPTH)) begin
          status = ST_FULL;
        end else begin
          nwr    = fire;
          status = ST_ADDED;
        end
      end
      OP_TAKE: begin
        if (ucount_r != '0) begin
          upop   = fire;
          status = ST_URGENT;
        end else if (ncount_r != '0) begin
          nrd    = fire;
          status = ST_NORMAL;
        end else begin
          status = ST_EMPTY;
        end
      end
      default: status = ST_EMPTY;
    endcase
  end

  assign toggle = upop || nrd;

  // Each cell decides on its own whether it keeps, takes the new entry or shifts.
  for (genvar i = 0; i < URGENT_DEPTH; i++) begin : g_cell
    assign ge[i] = (ucount_r > UCW'(i)) && (u_r[i].sev >= req_data.sev);
    always_comb begin
      u_nxt[i] = u_r[i];
      if (ins && !ge[i]) begin
        if (i == 0) begin
          u_nxt[i] = new_ent;
        end else if (ge[(i == 0) ? 0 : i-1]) begin
          u_nxt[i] = new_ent;
        end else begin
          u_nxt[i] = u_r[(i == 0) ? 0 : i-1];
        end
      end else if (upop && (i < URGENT_DEPTH-1)) begin
        u_nxt[i] = u_r[(i < URGENT_DEPTH-1) ? i+1 : i];
      end
    end
    always_ff @(posedge clk) begin
      u_r[i] <= u_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (nwr) begin
      normal_mem[tail_r] <= new_ent;
    end
    if (nrd) begin
      rd_r <= normal_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucount_r  <= '0;
      ncount_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      parity_r  <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= fire;
      if (ins) begin
        ucount_r <= ucount_r + UCW'(1);
      end else if (upop) begin
        ucount_r <= ucount_r - UCW'(1);
      end
      if (nwr) begin
        ncount_r <= ncount_r + NCW'(1);
        tail_r   <= (tail_r == NIW'(NORMAL_DEPTH-1)) ? '0 : tail_r + NIW'(1);
      end else if (nrd) begin
        ncount_r <= ncount_r - NCW'(1);
        head_r   <= (head_r == NIW'(NORMAL_DEPTH-1)) ? '0 : head_r + NIW'(1);
      end
      if (toggle) begin
        parity_r <= ~parity_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_status_r   <= status;
      b_from_mem_r <= nrd;
      b_sel_r      <= toggle ? ~parity_r : 1'b0;
      b_ent_r      <= upop ? u_r[0] : '0;
    end
  end

  assign rsp_valid = b_valid_r;
  always_comb begin
    rsp_data.status          = b_status_r;
    rsp_data.served_id       = b_from_mem_r ? rd_r.id : b_ent_r.id;
    rsp_data.served_severity = b_from_mem_r ? rd_r.sev : b_ent_r.sev;
    rsp_data.server_select   = b_sel_r;
  end

endmodule

### rtl/core/tcps_outq.sv
// Result queue between the back end and the result port.
module tcps_outq
  import tcps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  out_rsp_t           wr_data,
  output logic               empty,
  input  logic               pop,
  output out_rsp_t           out_data,
  output logic [OUTQ_LW-1:0] level
);

  out_rsp_t            q_r [OUTQ_DEPTH];
  logic [OUTQ_IW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUTQ_LW-1:0]  cnt_r;
  logic                rd_en;

  assign empty    = (cnt_r == '0);
  assign rd_en    = pop && !empty;
  assign out_data = q_r[rd_ptr_r];
  assign level    = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_IW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_IW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + OUTQ_LW'(1);
      end else if (!wr_en && rd_en) begin
        cnt_r <= cnt_r - OUTQ_LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/core/tcps_checker.sv
// Port-level checks for the scheduler and the bind that attaches them.
module tcps_checker
  import tcps_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input out_rsp_t out_data
);

  // Leaving reset, the result queue is empty and the request queue is not full.
  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> empty && !full)
    else $error("queues not empty after reset");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.status == ST_ADDED || out_data.status == ST_FULL ||
                out_data.status == ST_URGENT || out_data.status == ST_NORMAL ||
                out_data.status == ST_EMPTY))
    else $error("undefined status code");

  // A request that served nothing carries no entry and no server choice.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_data.status == ST_ADDED || out_data.status == ST_FULL ||
               out_data.status == ST_EMPTY)
    |-> out_data.served_id == '0 && out_data.served_severity == '0 &&
        !out_data.server_select)
    else $error("nonzero fields on a result that served nothing");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed");

endmodule

bind two_class_priority_fifo_scheduler tcps_checker u_tcps_checker (.*);

### test/tb_top.sv
// Self-checking testbench for the two-class priority FIFO scheduler.
module tb_top;
  import tcps_pkg::*;

  localparam int URGENT_CAP = 16;
  localparam int NORMAL_CAP = 16;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     full;
  in_req_t  in_data = '0;
  logic     empty;
  logic     pop = 1'b0;
  out_rsp_t out_data;
  logic     cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  two_class_priority_fifo_scheduler #(
    .URGENT_DEPTH(URGENT_CAP),
    .NORMAL_DEPTH(NORMAL_CAP)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scheduler state as the testbench sees it.
  entry_t     urgent_entries[$];
  entry_t     normal_entries[$];
  logic       served_parity = 1'b0;
  logic [3:0] urgent_level = THRESHOLD_RESET;

  in_req_t  queued_requests[$];
  out_rsp_t expected_outcomes[$];
  int       error_count = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] pop_pattern = '1;
  int          pattern_age = 0;

  function automatic out_rsp_t schedule_request(in_req_t r);
    out_rsp_t rsp;
    entry_t   e;
    int       pos;
    rsp = '0;
    e.id = r.entry_id;
    e.sev = r.severity;
    if (r.mode == MODE_ADD) begin
      if (r.severity > urgent_level) begin
        if (urgent_entries.size() >= URGENT_CAP) begin
          rsp.status = ST_FULL;
        end else begin
          // Equal severities stay behind earlier arrivals.
          pos = 0;
          while (pos < urgent_entries.size() && urgent_entries[pos].sev >= r.severity) pos++;
          urgent_entries.insert(pos, e);
          rsp.status = ST_ADDED;
        end
      end else if (normal_entries.size() >= NORMAL_CAP) begin
        rsp.status = ST_FULL;
      end else begin
        normal_entries.push_back(e);
        rsp.status = ST_ADDED;
      end
    end else begin
      if (urgent_entries.size() > 0) begin
        e = urgent_entries.pop_front();
        rsp.status = ST_URGENT;
      end else if (normal_entries.size() > 0) begin
        e = normal_entries.pop_front();
        rsp.status = ST_NORMAL;
      end else begin
        rsp.status = ST_EMPTY;
      end
      if (rsp.status != ST_EMPTY) begin
        served_parity = ~served_parity;
        rsp.served_id = e.id;
        rsp.served_severity = e.sev;
        rsp.server_select = served_parity;
      end
    end
    return rsp;
  endfunction

  task automatic queue_add(logic [15:0] id, logic [3:0] sev);
    in_req_t r;
    r = '{mode: MODE_ADD, entry_id: id, severity: sev};
    queued_requests.push_back(r);
  endtask

  task automatic queue_take();
    in_req_t r;
    r = '{mode: MODE_TAKE, entry_id: 16'($urandom), severity: 4'($urandom)};
    queued_requests.push_back(r);
  endtask

  // Runs of adds that overflow a store, runs of takes that drain both,
  // and random mixes in between.
  task automatic queue_random_phase(int count);
    int kind;
    int len;
    int lo;
    int hi;
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(4, 24);
      lo = $urandom_range(0, 15);
      hi = (lo + 3 > 15) ? 15 : lo + 3;
      hi = $urandom_range(lo, hi);
      for (int k = 0; k < len && count > 0; k++) begin
        if (kind < 3) begin
          queue_add(16'($urandom), 4'($urandom_range(lo, hi)));
        end else if (kind < 5) begin
          queue_take();
        end else if ($urandom_range(0, 1) == 0) begin
          queue_add(16'($urandom), 4'($urandom));
        end else begin
          queue_take();
        end
        count--;
      end
    end
  endtask

  task automatic wait_until_idle();
    while (queued_requests.size() != 0 || push || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [3:0] level);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= level;
    urgent_level = level;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_outcomes.push_back(schedule_request(in_data));
      if (!(push && full)) begin
        if (gap_left != 0 || queued_requests.size() == 0) begin
          push <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          in_data <= queued_requests.pop_front();
          push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Result monitor; pop follows a rotating pattern that is redrawn now and then.
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && pop && !empty) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, status %0d id %0d", $time, out_data.status,
                 out_data.served_id);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_data.status !== want.status)
          report_field("status", want.status, out_data.status);
        if (out_data.served_id !== want.served_id)
          report_field("served_id", want.served_id, out_data.served_id);
        if (out_data.served_severity !== want.served_severity)
          report_field("served_severity", want.served_severity, out_data.served_severity);
        if (out_data.server_select !== want.server_select)
          report_field("server_select", want.server_select, out_data.server_select);
      end
    end
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: pop_pattern = '1;
        1: pop_pattern = 16'h0001 << $urandom_range(0, 15);
        default: pop_pattern = 16'($urandom) | 16'h0001;
      endcase
      pattern_age = $urandom_range(16, 96);
    end
    pattern_age--;
    pop <= pop_pattern[0];
    pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
  end

  initial begin
    logic [3:0] levels[8];
    levels = '{4'd0, 4'd15, 4'd9, 4'd2, 4'd14, 4'd6, 4'd1, 4'd5};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset threshold: take from nothing, both classes at their boundaries,
    // equal severities, then drain past empty.
    queue_take();
    queue_add(16'h0000, 4'd0);
    queue_add(16'hFFFF, 4'd15);
    queue_add(16'h5555, 4'd5);
    queue_add(16'h0106, 4'd6);
    queue_add(16'h0206, 4'd6);
    queue_add(16'hAAAA, 4'd10);
    queue_add(16'h0306, 4'd6);
    repeat (8) queue_take();
    wait_until_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3 || ph == 6) levels[ph] = 4'($urandom);
      write_threshold(levels[ph]);
      queue_random_phase(200);
      wait_until_idle();
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
